@@ rtl/nmpa_pkg.sv @@
`default_nettype none

package nmpa_pkg;

	localparam int RING_DEGREE = 256;
	localparam int IDX_W       = $clog2(RING_DEGREE);
	localparam int COEFF_W     = 32;
	localparam int FUNC_W      = 3;
	localparam int INDEX_W     = 8;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_LOAD_XI = 3'd0,
		FUNC_LOAD_S  = 3'd1,
		FUNC_LOAD_Y  = 3'd2,
		FUNC_RUN     = 3'd3,
		FUNC_READ    = 3'd4
	} func_t;

	localparam logic KIND_ACK  = 1'b0;
	localparam logic KIND_READ = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PRIME,
		ST_MUL,
		ST_DRAIN,
		ST_DUMP,
		ST_FLUSH,
		ST_RD
	} state_t;

	typedef struct packed {
		logic [FUNC_W-1:0]         func;
		logic [INDEX_W-1:0]        index;
		logic signed [COEFF_W-1:0] coeff_in;
		logic                      lead_mode;
	} cmd_t;

	typedef struct packed {
		logic                      kind;
		logic signed [COEFF_W-1:0] coeff_out;
	} res_t;

	// control shared by every cell of the chain
	typedef struct packed {
		logic s_wr;
		logic clr;
		logic mul_en;
		logic acc_en;
		logic dump;
	} cell_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/nmpa_cell.sv @@
`default_nettype none

module nmpa_cell (
	input  wire logic                            clk,
	input  wire nmpa_pkg::cell_ctrl_t            ctrl,
	input  wire logic                            sel,
	input  wire logic [nmpa_pkg::COEFF_W-1:0]    s_data,
	input  wire logic [nmpa_pkg::COEFF_W-1:0]    xa,
	input  wire logic [nmpa_pkg::COEFF_W-1:0]    rot_in,
	input  wire logic [nmpa_pkg::COEFF_W-1:0]    acc_in,
	output logic      [nmpa_pkg::COEFF_W-1:0]    rot_out,
	output logic      [nmpa_pkg::COEFF_W-1:0]    acc_out
);

	logic [nmpa_pkg::COEFF_W-1:0] s_q;
	logic [nmpa_pkg::COEFF_W-1:0] rot_q;
	logic [nmpa_pkg::COEFF_W-1:0] prod_s1;
	logic [nmpa_pkg::COEFF_W-1:0] acc_q;

	always_ff @(posedge clk) begin
		if (ctrl.s_wr && sel) begin
			s_q <= s_data;
		end
	end

	// rotating copy of s: one step of multiplication by x per cycle while mul_en is high
	always_ff @(posedge clk) begin
		if (ctrl.clr) begin
			rot_q <= s_q;
		end else if (ctrl.mul_en) begin
			rot_q <= rot_in;
		end
	end

	// low half of the product is all the result keeps
	always_ff @(posedge clk) begin
		if (ctrl.mul_en) begin
			prod_s1 <= xa * rot_q;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.clr) begin
			acc_q <= '0;
		end else if (ctrl.acc_en) begin
			acc_q <= acc_q + prod_s1;
		end else if (ctrl.dump) begin
			acc_q <= acc_in;
		end
	end

	assign rot_out = rot_q;
	assign acc_out = acc_q;

endmodule

`default_nettype wire

@@ rtl/nmpa_chain.sv @@
`default_nettype none

module nmpa_chain (
	input  wire logic                            clk,
	input  wire nmpa_pkg::cell_ctrl_t            ctrl,
	input  wire logic [nmpa_pkg::IDX_W-1:0]      s_addr,
	input  wire logic [nmpa_pkg::COEFF_W-1:0]    s_data,
	input  wire logic [nmpa_pkg::COEFF_W-1:0]    xa,
	output logic      [nmpa_pkg::COEFF_W-1:0]    acc_head
);

	logic [nmpa_pkg::COEFF_W-1:0] rot_w [nmpa_pkg::RING_DEGREE];
	logic [nmpa_pkg::COEFF_W-1:0] acc_w [nmpa_pkg::RING_DEGREE];

	for (genvar r = 0; r < nmpa_pkg::RING_DEGREE; r++) begin : g_cell
		logic [nmpa_pkg::COEFF_W-1:0] rot_in;
		logic [nmpa_pkg::COEFF_W-1:0] acc_in;
		logic                         sel;

		// wrap from the top position back to zero negates (x^N = -1)
		if (r == 0) begin : g_head
			assign rot_in = -rot_w[nmpa_pkg::RING_DEGREE-1];
		end else begin : g_body
			assign rot_in = rot_w[r-1];
		end

		// accumulators drain toward cell zero
		if (r == nmpa_pkg::RING_DEGREE - 1) begin : g_tail
			assign acc_in = '0;
		end else begin : g_next
			assign acc_in = acc_w[r+1];
		end

		assign sel = (s_addr == nmpa_pkg::IDX_W'(r));

		nmpa_cell u_cell (
			.clk     (clk),
			.ctrl    (ctrl),
			.sel     (sel),
			.s_data  (s_data),
			.xa      (xa),
			.rot_in  (rot_in),
			.acc_in  (acc_in),
			.rot_out (rot_w[r]),
			.acc_out (acc_w[r])
		);
	end

	assign acc_head = acc_w[0];

endmodule

`default_nettype wire

@@ rtl/negacyclic_poly_mul_add_unit.sv @@
`default_nettype none

// Negacyclic multiply-add z = y + xi*s over Z[x]/(x^N + 1), N = RING_DEGREE.
// Command channel (cmd_valid, cmd_stall, cmd): a beat is taken when valid is
// high and stall low. Loads of xi, s and y return nothing. A read of z
// returns one beat (kind 1). A run returns one acknowledge beat (kind 0,
// coefficient 0). In full mode the chain of N cells each multiply one
// rotating s coefficient by the broadcast xi term and accumulate, then after
// a drain state the accumulators are shifted out of cell zero and y + acc is
// written into the z memory. In lead mode the multiply pass is skipped and
// y + xi is written instead. The block takes one command at a time.
// Result channel (res_valid, res_stall, res): one output register holds the
// beat; while it is stalled no command is taken, otherwise the next command
// is taken in the same cycle the result leaves. Reset clears control state
// and the output valid flag; memory contents are undefined until loaded.
module negacyclic_poly_mul_add_unit (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cmd_valid,
	output logic                  cmd_stall,
	input  wire nmpa_pkg::cmd_t   cmd,
	output logic                  res_valid,
	input  wire logic             res_stall,
	output nmpa_pkg::res_t        res
);

	localparam int IDX_W   = nmpa_pkg::IDX_W;
	localparam int COEFF_W = nmpa_pkg::COEFF_W;
	localparam int DEPTH   = nmpa_pkg::RING_DEGREE;

	nmpa_pkg::state_t     state_q;
	nmpa_pkg::state_t     state_d;
	nmpa_pkg::cell_ctrl_t ctrl;

	logic [IDX_W-1:0]   cnt_q;
	logic               lead_q;
	logic               rd_zero_q;
	logic               acc_en_s1;
	logic               wr_en_s1;
	logic [IDX_W-1:0]   wr_addr_s1;
	logic [COEFF_W-1:0] acc_s1;
	logic [COEFF_W-1:0] acc_head;

	logic               res_valid_q;
	nmpa_pkg::res_t     res_q;
	logic               res_load;
	nmpa_pkg::res_t     res_d;

	logic               cmd_fire;
	logic               in_ring;
	logic [IDX_W-1:0]   cmd_addr;
	logic               last;
	logic               chal_we;
	logic               mask_we;
	logic [IDX_W-1:0]   chal_raddr;

	logic [COEFF_W-1:0] chal_mem [DEPTH];
	logic [COEFF_W-1:0] mask_mem [DEPTH];
	logic [COEFF_W-1:0] res_mem  [DEPTH];
	logic [COEFF_W-1:0] chal_rd_q;
	logic [COEFF_W-1:0] mask_rd_q;
	logic [COEFF_W-1:0] res_rd_q;

	assign cmd_stall = (state_q != nmpa_pkg::ST_IDLE) || (res_valid_q && res_stall);
	assign cmd_fire  = cmd_valid && !cmd_stall;
	assign in_ring   = (32'(cmd.index) < DEPTH);
	assign cmd_addr  = IDX_W'(cmd.index);
	assign last      = (cnt_q == IDX_W'(DEPTH - 1));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			nmpa_pkg::ST_IDLE: begin
				if (cmd_fire && cmd.func == nmpa_pkg::FUNC_RUN) begin
					state_d = cmd.lead_mode ? nmpa_pkg::ST_DUMP : nmpa_pkg::ST_PRIME;
				end else if (cmd_fire && cmd.func == nmpa_pkg::FUNC_READ) begin
					state_d = nmpa_pkg::ST_RD;
				end
			end
			nmpa_pkg::ST_PRIME: state_d = nmpa_pkg::ST_MUL;
			nmpa_pkg::ST_MUL: begin
				if (last) begin
					state_d = nmpa_pkg::ST_DRAIN;
				end
			end
			nmpa_pkg::ST_DRAIN: state_d = nmpa_pkg::ST_DUMP;
			nmpa_pkg::ST_DUMP: begin
				if (last) begin
					state_d = nmpa_pkg::ST_FLUSH;
				end
			end
			nmpa_pkg::ST_FLUSH: state_d = nmpa_pkg::ST_IDLE;
			nmpa_pkg::ST_RD:    state_d = nmpa_pkg::ST_IDLE;
			default:            state_d = nmpa_pkg::ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		ctrl        = '0;
		ctrl.s_wr   = cmd_fire && cmd.func == nmpa_pkg::FUNC_LOAD_S && in_ring;
		ctrl.acc_en = acc_en_s1;
		chal_we     = cmd_fire && cmd.func == nmpa_pkg::FUNC_LOAD_XI && in_ring;
		mask_we     = cmd_fire && cmd.func == nmpa_pkg::FUNC_LOAD_Y && in_ring;
		chal_raddr  = cnt_q;
		res_load    = 1'b0;
		res_d       = '0;
		case (state_q)
			nmpa_pkg::ST_PRIME: begin
				ctrl.clr   = 1'b1;
				chal_raddr = '0;
			end
			nmpa_pkg::ST_MUL: begin
				ctrl.mul_en = 1'b1;
				// fetch the next xi term in the cycle before it is used
				chal_raddr  = last ? '0 : cnt_q + 1'b1;
			end
			nmpa_pkg::ST_DUMP: begin
				ctrl.dump = 1'b1;
			end
			nmpa_pkg::ST_FLUSH: begin
				res_load        = 1'b1;
				res_d.kind      = nmpa_pkg::KIND_ACK;
				res_d.coeff_out = '0;
			end
			nmpa_pkg::ST_RD: begin
				res_load        = 1'b1;
				res_d.kind      = nmpa_pkg::KIND_READ;
				res_d.coeff_out = rd_zero_q ? '0 : res_rd_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= nmpa_pkg::ST_IDLE;
			cnt_q     <= '0;
			acc_en_s1 <= 1'b0;
			wr_en_s1  <= 1'b0;
		end else begin
			state_q   <= state_d;
			acc_en_s1 <= ctrl.mul_en;
			wr_en_s1  <= (state_q == nmpa_pkg::ST_DUMP);
			if (state_d != state_q) begin
				cnt_q <= '0;
			end else if (state_q == nmpa_pkg::ST_MUL || state_q == nmpa_pkg::ST_DUMP) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_fire && cmd.func == nmpa_pkg::FUNC_RUN) begin
			lead_q <= cmd.lead_mode;
		end
		if (cmd_fire && cmd.func == nmpa_pkg::FUNC_READ) begin
			rd_zero_q <= !in_ring;
		end
		wr_addr_s1 <= cnt_q;
		acc_s1     <= acc_head;
	end

	// xi store: loaded by index, read in order during a run
	always_ff @(posedge clk) begin
		if (chal_we) begin
			chal_mem[cmd_addr] <= cmd.coeff_in;
		end
		chal_rd_q <= chal_mem[chal_raddr];
	end

	// y store
	always_ff @(posedge clk) begin
		if (mask_we) begin
			mask_mem[cmd_addr] <= cmd.coeff_in;
		end
		mask_rd_q <= mask_mem[cnt_q];
	end

	// z store: each coefficient is written in the cycle after the dump step that shifts it out
	always_ff @(posedge clk) begin
		if (wr_en_s1) begin
			res_mem[wr_addr_s1] <= mask_rd_q + (lead_q ? chal_rd_q : acc_s1);
		end
		res_rd_q <= res_mem[cmd_addr];
	end

	nmpa_chain u_chain (
		.clk      (clk),
		.ctrl     (ctrl),
		.s_addr   (cmd_addr),
		.s_data   (cmd.coeff_in),
		.xa       (chal_rd_q),
		.acc_head (acc_head)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (res_valid_q && !res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q <= res_d;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	a_flush_acks: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == nmpa_pkg::ST_FLUSH |=> res_valid && res.kind == nmpa_pkg::KIND_ACK)
		else $error("run finished without an acknowledge beat");

	a_write_in_dump: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en_s1 |-> (state_q == nmpa_pkg::ST_DUMP || state_q == nmpa_pkg::ST_FLUSH))
		else $error("z store written outside the drain pass");

	a_acc_after_mul: assert property (@(posedge clk) disable iff (!arst_n)
		acc_en_s1 |-> (state_q == nmpa_pkg::ST_MUL || state_q == nmpa_pkg::ST_DRAIN))
		else $error("accumulate outside the multiply pass");

	a_no_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |-> (!res_valid_q || $past(res_valid_q && !res_stall) || !$past(res_valid_q)))
		else $error("result register overwritten while occupied");

endmodule

`default_nettype wire
